>>> hdl/rled_pkg.sv
`timescale 1ns / 1ps

package rled_pkg;

    // Configuration register layout.
    localparam int CFG_BITS     = 11;
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROW_COUNT = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_COL_COUNT = 1'b1;
    localparam logic [CFG_BITS-1:0]     CFG_RESET     = 11'd1024;

    // Result fields.
    localparam int POS_BITS = 10;
    localparam logic DIR_VERT = 1'b0;
    localparam logic DIR_HORZ = 1'b1;

    // Result queue.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_CW    = 4;

    typedef struct packed {
        logic [POS_BITS-1:0] row;
        logic [POS_BITS-1:0] col;
        logic                dir;
        logic                peak;
        logic                last;
    } t_res;

endpackage

>>> hdl/rled_ram.sv
`timescale 1ns / 1ps

module rled_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // A read of the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

>>> hdl/raster_local_extremum_detector.sv
`timescale 1ns / 1ps
// A pixel's results pass the stage 1 registers and the result queue before being output.
// Throughput: one pixel per cycle while the result queue has room; the line buffer is
// read on accept and written back by stage 1, with forwarding for a one-column frame.
// A pixel with two hits needs two output beats, so the output port sets the rate then.
// Reset (synchronous, active low) clears position, left pixels, pipeline, result
// queue and sets both frame sizes to 1024; the line buffer keeps its contents.

module raster_local_extremum_detector #(
    parameter int MAX_COLS   = 1024,
    parameter int MAX_ROWS   = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Configuration write port.
    input  logic                                   i_cfg_wr_en,
    input  logic [rled_pkg::CFG_IDX_BITS-1:0]      i_cfg_addr,
    input  logic [rled_pkg::CFG_BITS-1:0]          i_cfg_wdata,
    // Pixel stream.
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((PIXEL_BITS+7)/8)*8-1:0]        s_axis_tdata,  // pixel
    // Result stream.
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [23:0]                            m_axis_tdata,  // center_row, center_col
    output logic [1:0]                             m_axis_tuser,  // direction, is_peak
    output logic                                   m_axis_tlast
);

    import rled_pkg::*;

    localparam int RAW = $clog2(MAX_ROWS);
    localparam int CAW = $clog2(MAX_COLS);
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int CCW = $clog2(MAX_COLS + 1);
    localparam int CW0 = (RCW > CCW) ? RCW : CCW;
    localparam int CW  = (CW0 > CFG_BITS) ? CW0 : CFG_BITS;

    // Configuration.
    logic [CFG_BITS-1:0] r_row_count, r_col_count;
    logic [CW-1:0]       rows_eff, cols_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= CFG_RESET;
            r_col_count <= CFG_RESET;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_addr == REG_ROW_COUNT) begin
                r_row_count <= i_cfg_wdata;
            end else begin
                r_col_count <= i_cfg_wdata;
            end
        end
    end

    always_comb begin
        if (r_row_count == '0) begin
            rows_eff = CW'(1);
        end else if (CW'(r_row_count) > CW'(MAX_ROWS)) begin
            rows_eff = CW'(MAX_ROWS);
        end else begin
            rows_eff = CW'(r_row_count);
        end
        if (r_col_count == '0) begin
            cols_eff = CW'(1);
        end else if (CW'(r_col_count) > CW'(MAX_COLS)) begin
            cols_eff = CW'(MAX_COLS);
        end else begin
            cols_eff = CW'(r_col_count);
        end
    end

    // Stage 0: position, horizontal test, line buffer read.
    logic                         r_rst_done;
    logic [RAW-1:0]               r_row, n_row;
    logic [CAW-1:0]               r_col, n_col;
    logic signed [PIXEL_BITS-1:0] r_left, r_left2;
    logic signed [PIXEL_BITS-1:0] px;
    logic [CW-1:0]                row_e, col_e, col_inc, row_inc;
    logic                         in_fire;
    logic                         h_peak, h_valley;

    assign px      = s_axis_tdata[PIXEL_BITS-1:0];
    assign in_fire = s_axis_tvalid && s_axis_tready;

    always_comb begin
        if (CW'(r_row) >= rows_eff) begin
            row_e = '0;
            col_e = '0;
        end else if (CW'(r_col) >= cols_eff) begin
            col_e = '0;
            row_e = (CW'(r_row) + CW'(1) >= rows_eff) ? '0 : CW'(r_row) + CW'(1);
        end else begin
            row_e = CW'(r_row);
            col_e = CW'(r_col);
        end
        col_inc = col_e + CW'(1);
        row_inc = row_e + CW'(1);
        if (col_inc >= cols_eff) begin
            n_col = '0;
            n_row = (row_inc >= rows_eff) ? '0 : RAW'(row_inc);
        end else begin
            n_col = CAW'(col_inc);
            n_row = RAW'(row_e);
        end
        h_peak   = (r_left > r_left2) && (r_left > px);
        h_valley = (r_left < r_left2) && (r_left < px);
    end

    // Stage 1 registers.
    logic                         r_s1_vld;
    logic signed [PIXEL_BITS-1:0] r_s1_px;
    logic [RAW-1:0]               r_s1_row;
    logic [CAW-1:0]               r_s1_col;
    logic                         r_s1_ven;
    logic                         r_s1_hhit;
    logic                         r_s1_hpeak;
    logic                         r_s1_fwd;
    logic [2*PIXEL_BITS-1:0]      r_s1_fwd_data;

    logic [2*PIXEL_BITS-1:0]      rd_data, lb_data, wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_left     <= '0;
            r_left2    <= '0;
            r_s1_vld   <= 1'b0;
            r_s1_fwd   <= 1'b0;
            r_rst_done <= 1'b0;
        end else begin
            r_rst_done <= 1'b1;
            r_s1_vld   <= in_fire;
            // A one-column frame reads the entry that stage 1 writes in the same cycle.
            r_s1_fwd   <= in_fire && r_s1_vld && (r_s1_col == CAW'(col_e));
            if (in_fire) begin
                r_row   <= n_row;
                r_col   <= n_col;
                r_left  <= px;
                r_left2 <= r_left;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_px       <= px;
            r_s1_row      <= RAW'(row_e);
            r_s1_col      <= CAW'(col_e);
            r_s1_ven      <= (row_e >= CW'(2));
            r_s1_hhit     <= (col_e >= CW'(2)) && (h_peak || h_valley);
            r_s1_hpeak    <= h_peak;
            r_s1_fwd_data <= wr_data;
        end
    end

    // Line buffer entry: upper half is two rows above, lower half one row above.
    rled_ram #(
        .WIDTH (2 * PIXEL_BITS),
        .DEPTH (MAX_COLS)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_wr_en   (r_s1_vld),
        .i_wr_addr (r_s1_col),
        .i_wr_data (wr_data),
        .i_rd_en   (in_fire),
        .i_rd_addr (CAW'(col_e)),
        .o_rd_data (rd_data)
    );

    // Stage 1: vertical test and write-back.
    logic signed [PIXEL_BITS-1:0] up1, up2;
    logic                         v_peak, v_valley, v_hit, h_hit;
    t_res                         res_v, res_h, res_first;
    logic [1:0]                   n_push;

    always_comb begin
        lb_data  = r_s1_fwd ? r_s1_fwd_data : rd_data;
        up1      = lb_data[PIXEL_BITS-1:0];
        up2      = lb_data[2*PIXEL_BITS-1:PIXEL_BITS];
        wr_data  = {up1, r_s1_px};
        v_peak   = (up1 > up2) && (up1 > r_s1_px);
        v_valley = (up1 < up2) && (up1 < r_s1_px);
        v_hit    = r_s1_vld && r_s1_ven && (v_peak || v_valley);
        h_hit    = r_s1_vld && r_s1_hhit;

        res_v.row  = POS_BITS'(r_s1_row - RAW'(1));
        res_v.col  = POS_BITS'(r_s1_col);
        res_v.dir  = DIR_VERT;
        res_v.peak = v_peak;
        res_v.last = !h_hit;

        res_h.row  = POS_BITS'(r_s1_row);
        res_h.col  = POS_BITS'(r_s1_col - CAW'(1));
        res_h.dir  = DIR_HORZ;
        res_h.peak = r_s1_hpeak;
        res_h.last = 1'b1;

        res_first = v_hit ? res_v : res_h;
        n_push    = 2'(v_hit) + 2'(h_hit);
    end

    // Result queue.
    t_res               r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_CW-1:0] r_count;
    logic               out_fire;

    assign out_fire = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_AW'(n_push);
            if (out_fire) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_count <= r_count + FIFO_CW'(n_push) - FIFO_CW'(out_fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_push != 2'd0) begin
            r_fifo[r_wr_ptr] <= res_first;
        end
        if (n_push == 2'd2) begin
            r_fifo[r_wr_ptr + FIFO_AW'(1)] <= res_h;
        end
    end

    // Room for the item in stage 1 and the one accepted now, two beats each.
    assign s_axis_tready = r_rst_done &&
        ((5'(r_count) + (r_s1_vld ? 5'd2 : 5'd0)) <= 5'(FIFO_DEPTH - 2));

    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tdata  = {4'b0000, r_fifo[r_rd_ptr].col, r_fifo[r_rd_ptr].row};
    assign m_axis_tuser  = {r_fifo[r_rd_ptr].peak, r_fifo[r_rd_ptr].dir};
    assign m_axis_tlast  = r_fifo[r_rd_ptr].last;

`ifndef SYNTHESIS
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_fwd_needs_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_fwd |-> r_s1_vld)
        else $error("forwarding without an item in stage 1");

    a_s1_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_s1_vld)
        else $error("accepted pixel did not reach stage 1");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire |=> r_count <= $past(r_count) + FIFO_CW'(1))
        else $error("queue grew by more than one beat while draining");
`endif

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import rled_pkg::*;

    localparam int LINE_LEN    = 1024;
    localparam int ROWS_MAX    = 1024;
    localparam int CYCLE_LIMIT = 300000;
    localparam int FILL_COLS   = 128;
    localparam int MIXED_ITEMS = 1620;

    localparam int IDLE_NONE  = 0;
    localparam int IDLE_SEND  = 1;
    localparam int IDLE_RECV  = 2;
    localparam int IDLE_BOTH  = 3;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_addr = REG_ROW_COUNT;
    logic [CFG_BITS-1:0] i_cfg_wdata = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [15:0]         s_axis_tdata = '0;   // pixel
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [23:0]         m_axis_tdata;        // center_row, center_col
    logic [1:0]          m_axis_tuser;        // direction, is_peak
    logic                m_axis_tlast;

    raster_local_extremum_detector u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow of the detector: line buffers, left pixels, raster position and frame size.
    logic signed [15:0] line_above  [LINE_LEN];
    logic signed [15:0] line_above2 [LINE_LEN];
    logic signed [15:0] left_px  = '0;
    logic signed [15:0] left2_px = '0;
    int                 pos_row = 0;
    int                 pos_col = 0;
    logic [CFG_BITS-1:0] frame_rows_reg = CFG_RESET;
    logic [CFG_BITS-1:0] frame_cols_reg = CFG_RESET;

    logic [15:0] pixel_q[$];
    t_res        extremum_q[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int cycles = 0;

    function automatic int eff_size(input logic [CFG_BITS-1:0] v, input int max_size);
        if (v == 0) return 1;
        if (v > max_size) return max_size;
        return v;
    endfunction

    // 1 for a strict maximum, 0 for a strict minimum, -1 otherwise.
    function automatic int extremum_kind(input logic signed [15:0] a,
                                         input logic signed [15:0] mid,
                                         input logic signed [15:0] b);
        if (mid > a && mid > b) return 1;
        if (mid < a && mid < b) return 0;
        return -1;
    endfunction

    task automatic predict_extrema(input logic signed [15:0] px);
        int   rows;
        int   cols;
        int   kind;
        bit   vert_hit;
        bit   horz_hit;
        t_res vert;
        t_res horz;
        rows = eff_size(frame_rows_reg, ROWS_MAX);
        cols = eff_size(frame_cols_reg, LINE_LEN);
        vert_hit = 1'b0;
        horz_hit = 1'b0;
        vert = '0;
        horz = '0;
        // A shrunk frame may leave the position outside; restart before taking the pixel.
        if (pos_row >= rows) begin
            pos_row = 0;
            pos_col = 0;
        end else if (pos_col >= cols) begin
            pos_col = 0;
            pos_row = (pos_row + 1 >= rows) ? 0 : pos_row + 1;
        end
        if (pos_row >= 2) begin
            kind = extremum_kind(line_above2[pos_col], line_above[pos_col], px);
            if (kind >= 0) begin
                vert_hit = 1'b1;
                vert.row  = POS_BITS'(pos_row - 1);
                vert.col  = POS_BITS'(pos_col);
                vert.dir  = DIR_VERT;
                vert.peak = kind[0];
            end
        end
        if (pos_col >= 2) begin
            kind = extremum_kind(left2_px, left_px, px);
            if (kind >= 0) begin
                horz_hit = 1'b1;
                horz.row  = POS_BITS'(pos_row);
                horz.col  = POS_BITS'(pos_col - 1);
                horz.dir  = DIR_HORZ;
                horz.peak = kind[0];
                horz.last = 1'b1;
            end
        end
        if (vert_hit) begin
            vert.last = !horz_hit;
            extremum_q.push_back(vert);
        end
        if (horz_hit) extremum_q.push_back(horz);
        line_above2[pos_col] = line_above[pos_col];
        line_above[pos_col]  = px;
        left2_px = left_px;
        left_px  = px;
        if (pos_col + 1 >= cols) begin
            pos_col = 0;
            pos_row = (pos_row + 1 >= rows) ? 0 : pos_row + 1;
        end else begin
            pos_col = pos_col + 1;
        end
    endtask

    task automatic send_pixel(input logic [15:0] px);
        predict_extrema(px);
        pixel_q.push_back(px);
    endtask

    // Mix of extremes, a narrow band that makes equal neighbours common, and full range.
    function automatic logic [15:0] pick_pixel();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0: return 16'h8000;
            1: return 16'h7FFF;
            2, 3, 4: return 16'($urandom_range(6)) - 16'd3;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic wait_drained();
        while (pixel_q.size() != 0 || s_axis_tvalid || extremum_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_frame(input logic [CFG_BITS-1:0] rows, input logic [CFG_BITS-1:0] cols);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= REG_ROW_COUNT;
        i_cfg_wdata <= rows;
        @(posedge i_clk);
        i_cfg_addr  <= REG_COL_COUNT;
        i_cfg_wdata <= cols;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        frame_rows_reg = rows;
        frame_cols_reg = cols;
    endtask

    task automatic set_idling(input int mode);
        send_idle_pct  = (mode == IDLE_SEND) ? 65 : (mode == IDLE_BOTH) ? 11 : 0;
        recv_stall_pct = (mode == IDLE_RECV) ? 65 : (mode == IDLE_BOTH) ? 11 : 0;
    endtask

    always @(posedge i_clk) begin : pixel_driver
        bit taken;
        taken = s_axis_tvalid && s_axis_tready;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (taken) pixel_q.delete(0);
            if (!s_axis_tvalid || taken) begin
                if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pixel_q[0];
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_res want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (extremum_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected beat: row %0d col %0d dir %0b peak %0b last %0b",
                                 m_axis_tdata[9:0], m_axis_tdata[19:10], m_axis_tuser[0],
                                 m_axis_tuser[1], m_axis_tlast);
                end else begin
                    want = extremum_q.pop_front();
                    if (m_axis_tdata != {4'b0, want.col, want.row} ||
                        m_axis_tuser != {want.peak, want.dir} || m_axis_tlast != want.last) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: want r%0d c%0d d%0b p%0b l%0b got %h %b %b",
                                     want.row, want.col, want.dir, want.peak, want.last,
                                     m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL raster_local_extremum_detector");
            $finish;
        end
    end

    initial begin : stimulus
        logic [15:0] directed_px [21];
        logic [CFG_BITS-1:0] rows;
        logic [CFG_BITS-1:0] cols;
        int n_items;
        int sent;
        int ph;
        directed_px = '{16'h0001, 16'hFFFF, 16'h0000,
                        16'h8000, 16'h7FFF, 16'h8000,
                        16'h7FFF, 16'h8000, 16'h7FFF,
                        16'h8000, 16'h7FFF, 16'h8000,
                        16'd5, 16'd5, 16'd5,
                        16'd5, 16'd5, 16'd4,
                        16'd5, 16'd5, 16'd5};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Two full rows of a narrow frame, so every entry that a tall frame reads holds data.
        set_idling(IDLE_NONE);
        set_frame(CFG_RESET, CFG_BITS'(FILL_COLS));
        for (int i = 0; i < 2 * FILL_COLS; i++) send_pixel(pick_pixel());

        // Small frame with full-scale peaks and valleys both ways, then equal neighbours.
        wait_drained();
        set_frame(11'd3, 11'd3);
        foreach (directed_px[i]) send_pixel(directed_px[i]);

        sent = 0;
        ph = 0;
        while (sent < MIXED_ITEMS) begin
            case (ph)
                0: begin rows = 11'd1;    cols = 11'd1024; n_items = 150;  end
                // A one-pixel-wide frame that runs through every row and wraps.
                1: begin rows = 11'd2047; cols = 11'd0;    n_items = 1100; end
                2: begin rows = 11'd0;    cols = 11'd2;    n_items = 40;   end
                default: begin
                    if ($urandom_range(3) == 0) begin
                        // At most two rows means no vertical test, so any width is safe.
                        rows = 11'($urandom_range(2));
                        cols = 11'($urandom_range(2047));
                        n_items = 80;
                    end else begin
                        rows = 11'($urandom_range(1, 10));
                        cols = 11'($urandom_range(1, 10));
                        n_items = $urandom_range(40, 120);
                    end
                end
            endcase
            wait_drained();
            set_idling(ph % 4);
            set_frame(rows, cols);
            for (int i = 0; i < n_items; i++) send_pixel(pick_pixel());
            sent += n_items;
            ph++;
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS raster_local_extremum_detector");
        end else begin
            $display("FAIL raster_local_extremum_detector");
        end
        $finish;
    end

endmodule
